// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types for the double-ended queue: action and status codes,
// and the command that the controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Action codes carried by an input beat.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_LIST       = 3'd4;
  localparam logic [2:0] ACT_QUERY      = 3'd5;
  localparam logic [2:0] ACT_CLEAR      = 3'd6;

  // Status codes carried by a result beat.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Word width of one entry.
  localparam int unsigned WORD_W = 32;

  // Operation applied by every cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_F,
    OP_PUSH_B,
    OP_POP_F,
    OP_ROTATE
  } cell_op_t;

  // Command broadcast along the row.
  typedef struct packed {
    cell_op_t           op;
    logic [WORD_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Cell 0 holds the front entry; entries
// occupy cells 0 to count-1. Each cell takes a word from its neighbor, from
// the head cell or from the command, as the broadcast operation says.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  logic                          clk,
  input  deq_pkg::cell_cmd_t            cmd_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [deq_pkg::WORD_W-1:0]    left_i,
  input  logic [deq_pkg::WORD_W-1:0]    right_i,
  input  logic [deq_pkg::WORD_W-1:0]    head_i,
  output logic [deq_pkg::WORD_W-1:0]    data_o,
  output logic [deq_pkg::WORD_W-1:0]    tail_data_o
);

  localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(IDX + 1);

  logic [deq_pkg::WORD_W-1:0] data_r;
  logic [deq_pkg::WORD_W-1:0] data_nxt;
  logic                       is_slot;
  logic                       is_tail;
  logic                       in_use;

  // Position of this cell relative to the current fill.
  assign is_slot = (count_i == MY_POS);
  assign is_tail = (count_i == NEXT_POS);
  assign in_use  = (count_i > MY_POS);

  // Next word for this cell.
  always_comb begin
    data_nxt = data_r;
    case (cmd_i.op)
      deq_pkg::OP_PUSH_F: data_nxt = left_i;
      deq_pkg::OP_PUSH_B: begin
        if (is_slot) data_nxt = cmd_i.value;
      end
      deq_pkg::OP_POP_F:  data_nxt = right_i;
      deq_pkg::OP_ROTATE: begin
        if (is_tail) begin
          data_nxt = head_i;
        end else if (in_use) begin
          data_nxt = right_i;
        end
      end
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o      = data_r;
  // The back entry drives the shared tail bus; every other cell drives zero.
  assign tail_data_o = is_tail ? data_r : '0;

endmodule

// ===== rtl/core/double_ended_queue_top.sv =====
// A result beat is registered, valid in the cycle after its input is accepted.
// Throughput: one input beat per cycle for push, pop, query and clear actions
// while the output is taken. A list action emits one entry per cycle while the
// output is taken and holds the input to its last entry; the row rotates once.
// Reset clears the fill count and the control state; the cell words are not
// cleared, and only held entries are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed words, built as a row of shifting
// storage cells with the front entry always in cell 0.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_data,
  output logic [1:0]         out_status,
  output logic               out_is_empty,
  output logic               out_last
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            list_left_r, list_left_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [deq_pkg::WORD_W-1:0]  out_data_r, out_data_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic                        out_is_empty_r, out_is_empty_nxt;
  logic                        out_last_r, out_last_nxt;

  deq_pkg::cell_cmd_t          cmd;
  logic [deq_pkg::WORD_W-1:0]  cell_data [DEPTH];
  logic [deq_pkg::WORD_W-1:0]  tail_data [DEPTH];
  logic [deq_pkg::WORD_W-1:0]  tail_word;
  logic                        out_free;
  logic                        in_accept;
  logic                        q_empty;
  logic                        q_full;

  // Handshake: a new beat is taken when idle and the output slot frees up.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_valid && in_ready;
  assign q_empty   = (count_r == '0);
  assign q_full    = (count_r == FULL_CNT);

  // Back entry: at most one cell drives the tail bus (none when the queue is empty).
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | tail_data[i];
    end
  end

  // Action decode and list sequencing.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    list_left_nxt    = list_left_r;
    cmd.op           = deq_pkg::OP_HOLD;
    cmd.value        = in_value;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    out_status_nxt   = out_status_r;
    out_is_empty_nxt = out_is_empty_r;
    out_last_nxt     = out_last_r;

    if (in_accept) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = deq_pkg::STAT_OK;
      out_last_nxt   = 1'b1;
      case (in_action)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (q_full) begin
            out_status_nxt = deq_pkg::STAT_FULL;
          end else begin
            cmd.op    = deq_pkg::OP_PUSH_F;
            count_nxt = count_r + ONE_CNT;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (q_full) begin
            out_status_nxt = deq_pkg::STAT_FULL;
          end else begin
            cmd.op    = deq_pkg::OP_PUSH_B;
            count_nxt = count_r + ONE_CNT;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (q_empty) begin
            out_status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            out_data_nxt = cell_data[0];
            cmd.op       = deq_pkg::OP_POP_F;
            count_nxt    = count_r - ONE_CNT;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (q_empty) begin
            out_status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            out_data_nxt = tail_word;
            count_nxt    = count_r - ONE_CNT;
          end
        end
        deq_pkg::ACT_LIST: begin
          if (q_empty) begin
            out_status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            // First entry now; the rest stream while the row rotates.
            out_data_nxt  = cell_data[0];
            out_last_nxt  = (count_r == ONE_CNT);
            cmd.op        = deq_pkg::OP_ROTATE;
            list_left_nxt = count_r - ONE_CNT;
            if (count_r != ONE_CNT) state_nxt = ST_LIST;
          end
        end
        deq_pkg::ACT_QUERY: begin
          out_status_nxt = q_empty ? deq_pkg::STAT_EMPTY : deq_pkg::STAT_OK;
        end
        deq_pkg::ACT_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
      out_is_empty_nxt = (count_nxt == '0);
    end else if ((state_r == ST_LIST) && out_free) begin
      out_valid_nxt    = 1'b1;
      out_data_nxt     = cell_data[0];
      out_status_nxt   = deq_pkg::STAT_OK;
      out_is_empty_nxt = 1'b0;
      out_last_nxt     = (list_left_r == ONE_CNT);
      cmd.op           = deq_pkg::OP_ROTATE;
      list_left_nxt    = list_left_r - ONE_CNT;
      if (list_left_r == ONE_CNT) state_nxt = ST_IDLE;
    end
  end

  // Row of storage cells; each hands its word to a neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_w;
    logic [deq_pkg::WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    deq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd_i       (cmd),
      .count_i     (count_r),
      .left_i      (left_w),
      .right_i     (right_w),
      .head_i      (cell_data[0]),
      .data_o      (cell_data[g]),
      .tail_data_o (tail_data[g])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      list_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_left_r <= list_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_data_r     <= out_data_nxt;
    out_status_r   <= out_status_nxt;
    out_is_empty_r <= out_is_empty_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = $signed(out_data_r);
  assign out_status   = out_status_r;
  assign out_is_empty = out_is_empty_r;
  assign out_last     = out_last_r;

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  // While streaming a list, the entries still to send are fewer than held.
  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> (list_left_r != '0) && (list_left_r < count_r))
    else $error("list counter out of range");

  // A push that is not refused grows the queue by one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !q_full &&
     (in_action == deq_pkg::ACT_PUSH_FRONT || in_action == deq_pkg::ACT_PUSH_BACK))
    |=> (count_r == $past(count_r) + ONE_CNT))
    else $error("push did not grow the queue");

  // A list never runs past the entries it has to send.
  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST && out_free && list_left_r == ONE_CNT) |=>
    (state_r == ST_IDLE && out_last_r))
    else $error("list did not end on its last entry");

endmodule

// ===== verif/tb_double_ended_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking bench for the double-ended queue. A short table of directed
// actions covers the empty, full and wrapped cases and the word extremes.
// Weighted random traffic follows, with phases that lean to filling or to
// draining. A shadow ring inside the bench predicts every result beat. Both
// handshakes idle at random, except in recurring stretches of cycles with no idling.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 312;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // One result beat as seen on the output channel.
  typedef struct {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               is_empty;
    logic               last;
  } res_t;

  // One row of the directed table. A typed row carries its own expected
  // single result; the other rows are checked against the shadow ring.
  typedef struct {
    logic [2:0]  act;
    logic [31:0] val;
    int          reps;
    bit          typed;
    res_t        want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_data;
  logic [1:0]         out_status;
  logic               out_is_empty;
  logic               out_last;

  // Shadow copy of the queue contents.
  logic [31:0] shadow_word [DEPTH];
  logic [4:0]  shadow_front;
  logic [5:0]  shadow_count;

  res_t awaited [$];
  row_t plan [$];
  res_t head_result;
  int   mismatch_count = 0;
  int   cyc = 0;
  logic calm;

  double_ended_queue_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_is_empty (out_is_empty),
    .out_last     (out_last)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle count; a recurring window has no idling on either side.
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end
  assign calm = (cyc % 1024) >= 768;

  // Outside the calm window, the receiver stalls in about 8 percent of cycles.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  function automatic res_t mk_res(logic [31:0] d, logic [1:0] s, logic e, logic l);
    res_t r;
    r.data     = d;
    r.status   = s;
    r.is_empty = e;
    r.last     = l;
    return r;
  endfunction

  function automatic logic [4:0] ring_at(int off);
    return 5'((shadow_front + off) % DEPTH);
  endfunction

  // Apply one action to the shadow ring; queue its results when keep is set.
  task automatic shadow_apply(input logic [2:0] act, input logic [31:0] val, input bit keep);
    logic [31:0] data;
    logic [1:0]  stat;
    data = '0;
    stat = deq_pkg::STAT_OK;
    if (act == deq_pkg::ACT_LIST) begin
      if (shadow_count == 0) begin
        if (keep) awaited.push_back(mk_res('0, deq_pkg::STAT_EMPTY, 1'b1, 1'b1));
      end else begin
        for (int i = 0; i < shadow_count; i++) begin
          if (keep) begin
            awaited.push_back(mk_res(shadow_word[ring_at(i)], deq_pkg::STAT_OK, 1'b0,
                                     (i + 1) == shadow_count));
          end
        end
      end
    end else begin
      case (act)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (shadow_count >= DEPTH) begin
            stat = deq_pkg::STAT_FULL;
          end else begin
            shadow_front = 5'((shadow_front + DEPTH - 1) % DEPTH);
            shadow_word[shadow_front] = val;
            shadow_count++;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (shadow_count >= DEPTH) begin
            stat = deq_pkg::STAT_FULL;
          end else begin
            shadow_word[ring_at(shadow_count)] = val;
            shadow_count++;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (shadow_count == 0) begin
            stat = deq_pkg::STAT_EMPTY;
          end else begin
            data = shadow_word[shadow_front];
            shadow_front = ring_at(1);
            shadow_count--;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (shadow_count == 0) begin
            stat = deq_pkg::STAT_EMPTY;
          end else begin
            data = shadow_word[ring_at(shadow_count - 1)];
            shadow_count--;
          end
        end
        deq_pkg::ACT_QUERY: begin
          stat = (shadow_count == 0) ? deq_pkg::STAT_EMPTY : deq_pkg::STAT_OK;
        end
        deq_pkg::ACT_CLEAR: begin
          shadow_front = '0;
          shadow_count = '0;
        end
        default: begin
        end
      endcase
      if (keep) awaited.push_back(mk_res(data, stat, shadow_count == 0, 1'b1));
    end
  endtask

  // Present one input beat, with random idle cycles ahead of it, and record
  // its expected results once it is accepted.
  task automatic send_beat(input logic [2:0] act, input logic [31:0] val,
                           input bit typed, input res_t want);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow_apply(act, val, !typed);
    if (typed) awaited.push_back(want);
  endtask

  task automatic add_row(input logic [2:0] act, input logic [31:0] val, input int reps,
                         input bit typed, input logic [31:0] d, input logic [1:0] s,
                         input logic e);
    row_t r;
    r.act   = act;
    r.val   = val;
    r.reps  = reps;
    r.typed = typed;
    r.want  = mk_res(d, s, e, 1'b1);
    plan.push_back(r);
  endtask

  // Word picker that favors the extremes and small values.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Result checker: each accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual data=%0d status=%0d",
                 $time, out_data, out_status);
        $display("%0t: unexpected beat, actual empty=%0b last=%0b",
                 $time, out_is_empty, out_last);
      end else begin
        head_result = awaited.pop_front();
        if (out_data !== head_result.data) begin
          mismatch_count++;
          $display("%0t: data expected %0d actual %0d", $time, head_result.data, out_data);
        end
        if (out_status !== head_result.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, head_result.status, out_status);
        end
        if (out_is_empty !== head_result.is_empty) begin
          mismatch_count++;
          $display("%0t: is_empty expected %0b actual %0b", $time, head_result.is_empty,
                   out_is_empty);
        end
        if (out_last !== head_result.last) begin
          mismatch_count++;
          $display("%0t: last expected %0b actual %0b", $time, head_result.last, out_last);
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    int   mode;
    int   left;
    int   r;
    int   push_share;
    bit   is_push;
    bit   at_front;
    logic [2:0] act;
    res_t none;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = deq_pkg::ACT_PUSH_FRONT;
    in_value  = '0;
    none      = mk_res('0, deq_pkg::STAT_OK, 1'b0, 1'b0);
    mode      = 0;
    left      = 0;
    shadow_front = '0;
    shadow_count = '0;
    foreach (shadow_word[i]) shadow_word[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty cases, extremes, full refusals, wrap and clear.
    add_row(deq_pkg::ACT_POP_FRONT,  32'h0,         1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);
    add_row(deq_pkg::ACT_POP_BACK,   32'h1234_5678, 1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);
    add_row(deq_pkg::ACT_LIST,       32'h0,         1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);
    add_row(deq_pkg::ACT_QUERY,      32'h0,         1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);
    add_row(deq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_PUSH_BACK,  32'h8000_0000, 1,  1, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_QUERY,      32'hFFFF_FFFF, 1,  1, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_LIST,       32'h0,         1,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_POP_FRONT,  32'h0,         1,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_POP_BACK,   32'h0,         1,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(ACT_UNUSED,              32'hFFFF_FFFF, 1,  1, 32'h0, deq_pkg::STAT_OK,    1'b1);
    add_row(deq_pkg::ACT_PUSH_BACK,  32'hA5A5_0000, 32, 0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_PUSH_FRONT, 32'h1111_1111, 1,  1, 32'h0, deq_pkg::STAT_FULL,  1'b0);
    add_row(deq_pkg::ACT_PUSH_BACK,  32'h2222_2222, 1,  1, 32'h0, deq_pkg::STAT_FULL,  1'b0);
    add_row(deq_pkg::ACT_LIST,       32'h0,         1,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_POP_FRONT,  32'h0,         5,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 7,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_LIST,       32'h0,         1,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_CLEAR,      32'h0,         1,  1, 32'h0, deq_pkg::STAT_OK,    1'b1);
    add_row(deq_pkg::ACT_LIST,       32'h0,         1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);
    add_row(deq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFD, 3,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_POP_BACK,   32'h0,         4,  0, 32'h0, deq_pkg::STAT_OK,    1'b0);
    add_row(deq_pkg::ACT_QUERY,      32'h0,         1,  1, 32'h0, deq_pkg::STAT_EMPTY, 1'b1);

    foreach (plan[k]) begin
      for (int i = 0; i < plan[k].reps; i++) begin
        send_beat(plan[k].act, plan[k].val + i, plan[k].typed, plan[k].want);
      end
    end

    // Random traffic in phases: 0 fills, 1 drains, 2 is balanced.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (left == 0) begin
        mode = $urandom_range(2);
        left = $urandom_range(20, 60);
      end
      left--;
      r = $urandom_range(99);
      if (r < 6) begin
        act = deq_pkg::ACT_LIST;
      end else if (r < 10) begin
        act = deq_pkg::ACT_QUERY;
      end else if (r < 11) begin
        act = deq_pkg::ACT_CLEAR;
      end else if (r < 13) begin
        act = ACT_UNUSED;
      end else begin
        push_share = (mode == 0) ? 85 : (mode == 1) ? 20 : 50;
        is_push  = $urandom_range(99) < push_share;
        at_front = 1'($urandom_range(1));
        if (is_push) act = at_front ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
        else         act = at_front ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
      end
      send_beat(act, pick_word(), 1'b0, none);
    end

    // Drain: wait for every expected beat, then a few cycles for stray ones.
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected beats never arrived", $time, awaited.size());
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_top.sv
verif/tb_double_ended_queue_top.sv
